// File: rtl/wtsp_pkg.sv
// package for the world-to-screen projection: register codes and fixed widths
`timescale 1ns / 1ps
package wtsp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW3_C01 = 3'd4,
    REG_ROW3_C23 = 3'd5,
    REG_ORIGIN   = 3'd6,
    REG_EXTENT   = 3'd7
  } reg_idx_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int CoefW    = 32;
  localparam int CoordW   = 32;
  localparam int OutW     = 32;
  localparam int WinW     = 16;

  // clip values are held to +-2^40 after the scale or divide
  localparam int ClipLimExp = 40;
  localparam int ClipW      = ClipLimExp + 2;

  // behind-viewer scaling: values beyond the limit saturate the clip range
  localparam int BehindScale = 100000;
  localparam int BehindLim   = 10995116;
  localparam int BehindW     = 25;

endpackage

// File: rtl/wtsp_dot.sv
// two-stage dot products of the point with matrix rows 0, 1 and 3
`timescale 1ns / 1ps
module wtsp_dot #(
  parameter int FracBits = 16,
  parameter int SumW     = 66 - FracBits
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic [2:0][wtsp_pkg::CoordW-1:0]        point_i,
  input  logic [2:0][3:0][wtsp_pkg::CoefW-1:0]    coef_i,
  output logic                                    valid_o,
  output logic [2:0][SumW-1:0]                    clip_o
);
  import wtsp_pkg::*;

  logic                          vld1_q, vld2_q;
  logic signed [2*CoefW-1:0]     prod_q [3][3];
  logic [2:0][SumW-1:0]          sum_d, sum_q;

  // stage 1: nine products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= $signed(coef_i[r][k]) * $signed(point_i[k]);
        end
      end
    end
  end

  // stage 2: floor-shifted products plus translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SumW'(prod_q[r][0] >>> FracBits) + SumW'(prod_q[r][1] >>> FracBits)
               + SumW'(prod_q[r][2] >>> FracBits) + SumW'($signed(coef_i[r][3]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o = vld2_q;
  assign clip_o  = sum_q;

endmodule

// File: rtl/wtsp_div.sv
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
`timescale 1ns / 1ps
module wtsp_div #(
  parameter int NumW     = 50,
  parameter int FracBits = 16,
  parameter int SideW    = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [1:0][NumW-1:0]     num_i,
  input  logic [NumW-1:0]          den_i,
  input  logic [SideW-1:0]         side_i,
  output logic                     valid_o,
  output logic [1:0][NumW+FracBits-1:0] quo_o,
  output logic [SideW-1:0]         side_o
);
  import wtsp_pkg::*;

  localparam int Steps = NumW + FracBits;

  logic                    vld  [Steps+1];
  logic [1:0][NumW-1:0]    rem  [Steps+1];
  logic [1:0][Steps-1:0]   dvd  [Steps+1];
  logic [NumW-1:0]         den  [Steps+1];
  logic [SideW-1:0]        side [Steps+1];

  // stage inputs
  assign vld[0]  = valid_i;
  assign den[0]  = den_i;
  assign side[0] = side_i;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem[0][l] = '0;
      dvd[0][l] = {num_i[l], FracBits'(0)};
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    logic [1:0][NumW-1:0]  rem_d;
    logic [1:0][Steps-1:0] dvd_d;
    logic [NumW:0]         trial [2];
    logic                  vld_q;
    logic [1:0][NumW-1:0]  rem_q;
    logic [1:0][Steps-1:0] dvd_q;
    logic [NumW-1:0]       den_q;
    logic [SideW-1:0]      side_q;

    // shift in the next dividend bit and try a subtract
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem[i][l], dvd[i][l][Steps-1]};
        if (trial[l] >= {1'b0, den[i]}) begin
          rem_d[l] = NumW'(trial[l] - {1'b0, den[i]});
          dvd_d[l] = {dvd[i][l][Steps-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[l][NumW-1:0];
          dvd_d[l] = {dvd[i][l][Steps-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        dvd_q  <= dvd_d;
        den_q  <= den[i];
        side_q <= side[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[i];
      end
    end

    assign vld[i+1]  = vld_q;
    assign rem[i+1]  = rem_q;
    assign dvd[i+1]  = dvd_q;
    assign den[i+1]  = den_q;
    assign side[i+1] = side_q;
  end

  assign valid_o = vld[Steps];
  assign quo_o   = dvd[Steps];
  assign side_o  = side[Steps];

endmodule

// File: rtl/wtsp_win.sv
// window mapping: scale by half extent, add origin, saturate; holds the output register
`timescale 1ns / 1ps
module wtsp_win #(
  parameter int FracBits = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [1:0][wtsp_pkg::ClipW-1:0]       clip_i,
  input  logic                                  behind_i,
  input  logic [1:0][wtsp_pkg::WinW-1:0]        origin_i,
  input  logic [1:0][wtsp_pkg::WinW-1:0]        extent_i,
  output logic                                  valid_o,
  output logic [1:0][wtsp_pkg::OutW-1:0]        screen_o,
  output logic                                  behind_o
);
  import wtsp_pkg::*;

  localparam int ProdW = ClipW + 1 + WinW + 1;
  localparam longint OneL = 64'sd1 <<< FracBits;
  localparam logic signed [ClipW:0] One = (ClipW + 1)'(OneL);
  localparam logic signed [ProdW-1:0] MaxV = ProdW'(64'sd2147483647);
  localparam logic signed [ProdW-1:0] MinV = ProdW'(-64'sd2147483648);

  logic                        vld1_q, vld2_q;
  logic signed [ProdW-1:0]     prod_q [2];
  logic                        beh1_q, beh2_q;
  logic [1:0][OutW-1:0]        scr_d, scr_q;
  logic signed [ClipW:0]       shifted [2];
  logic signed [ProdW-1:0]     sum [2];

  // stage a: (clip + 1) times extent
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l] = $signed({clip_i[l][ClipW-1], clip_i[l]}) + One;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        prod_q[l] <= ProdW'(shifted[l]) * ProdW'($signed({1'b0, extent_i[l]}));
      end
      beh1_q <= behind_i;
    end
  end

  // stage b: halve, add origin, saturate
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sum[l] = (prod_q[l] >>> 1) + (ProdW'($signed(origin_i[l])) <<< FracBits);
      if (sum[l] > MaxV) begin
        scr_d[l] = OutW'(MaxV);
      end else if (sum[l] < MinV) begin
        scr_d[l] = OutW'(MinV);
      end else begin
        scr_d[l] = sum[l][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scr_q  <= scr_d;
      beh2_q <= beh1_q;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  assign valid_o  = vld2_q;
  assign screen_o = scr_q;
  assign behind_o = beh2_q;

endmodule

// File: rtl/world_to_screen_projection.sv
// top level of the world-to-screen projection pipeline
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      tdata: point_x, point_y, point_z
//  m_axis    out        m_axis_tvalid/tready      tdata: screen_x, screen_y; tuser: behind_viewer
//  cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one point enters per cycle while no held result stalls the pipeline; a point passes the dot
// products, then the bit-per-stage divider (its depth is the dividend width plus the fraction
// bits), then the window mapping and output register
// reset clears the valid bits and the configuration registers
// a held result freezes the whole pipeline in place; s_axis_tready follows it
`timescale 1ns / 1ps
module world_to_screen_projection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,   // point_x, point_y, point_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [63:0]                   m_axis_tdata,   // screen_x, screen_y
  output logic                          m_axis_tuser,   // behind_viewer
  input  logic                          cfg_we_i,
  input  logic [wtsp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wtsp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import wtsp_pkg::*;

  localparam int SumW  = 66 - FRAC_BITS;
  localparam int Steps = SumW + FRAC_BITS;
  localparam int SideW = 3 + 2 * ClipW;
  localparam int Thr   = ((1 << FRAC_BITS) + 999) / 1000;
  localparam logic signed [SumW-1:0]  ThrS  = SumW'(Thr);
  localparam logic signed [SumW-1:0]  BLimS = SumW'(BehindLim);
  localparam logic signed [ClipW-1:0] ClipMax = ClipW'(64'sd1 <<< ClipLimExp);
  localparam logic [Steps-1:0]        QLim  = Steps'(64'd1 << ClipLimExp);

  logic [2:0][3:0][CoefW-1:0] coef_q;
  logic [1:0][WinW-1:0]       origin_q, extent_q;
  logic                       en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      origin_q <= '0;
      extent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROW0_C01: coef_q[0][1:0] <= cfg_wdata_i;
        REG_ROW0_C23: coef_q[0][3:2] <= cfg_wdata_i;
        REG_ROW1_C01: coef_q[1][1:0] <= cfg_wdata_i;
        REG_ROW1_C23: coef_q[1][3:2] <= cfg_wdata_i;
        REG_ROW3_C01: coef_q[2][1:0] <= cfg_wdata_i;
        REG_ROW3_C23: coef_q[2][3:2] <= cfg_wdata_i;
        REG_ORIGIN:   origin_q       <= cfg_wdata_i[31:0];
        REG_EXTENT:   extent_q       <= cfg_wdata_i[31:0];
      endcase
    end
  end

  // global advance: stall everything while the output is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // dot products
  logic                  dot_vld;
  logic [2:0][SumW-1:0]  clip;

  wtsp_dot #(.FracBits(FRAC_BITS), .SumW(SumW)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .point_i (s_axis_tdata),
    .coef_i  (coef_q),
    .valid_o (dot_vld),
    .clip_o  (clip)
  );

  // behind test, magnitudes and behind-path scaling
  logic                    behind;
  logic [1:0]              neg;
  logic [1:0][SumW-1:0]    mag;
  logic [1:0][ClipW-1:0]   bval;
  logic [SideW-1:0]        side_in, side_out;

  always_comb begin
    behind = $signed(clip[2]) < ThrS;
    for (int l = 0; l < 2; l++) begin
      neg[l] = clip[l][SumW-1];
      mag[l] = neg[l] ? SumW'(-$signed(clip[l])) : clip[l];
      if ($signed(clip[l]) > BLimS) begin
        bval[l] = ClipMax;
      end else if ($signed(clip[l]) < -BLimS) begin
        bval[l] = -ClipMax;
      end else begin
        bval[l] = ClipW'($signed(ClipW'($signed(clip[l][BehindW-1:0])))
                  * $signed(ClipW'(BehindScale)));
      end
    end
    side_in = {behind, neg, bval};
  end

  // divider
  logic                        div_vld;
  logic [1:0][Steps-1:0]       quo;

  wtsp_div #(.NumW(SumW), .FracBits(FRAC_BITS), .SideW(SideW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_vld),
    .num_i   (mag),
    .den_i   (clip[2]),
    .side_i  (side_in),
    .valid_o (div_vld),
    .quo_o   (quo),
    .side_o  (side_out)
  );

  // clamp quotient, restore sign, pick the behind path
  logic                    d_behind;
  logic [1:0]              d_neg;
  logic [1:0][ClipW-1:0]   d_bval, clip_sel;
  logic [ClipW-1:0]        qmag;

  always_comb begin
    {d_behind, d_neg, d_bval} = side_out;
    for (int l = 0; l < 2; l++) begin
      qmag = (quo[l] > QLim) ? ClipW'(QLim) : ClipW'(quo[l]);
      if (d_behind) begin
        clip_sel[l] = d_bval[l];
      end else if (d_neg[l]) begin
        clip_sel[l] = -qmag;
      end else begin
        clip_sel[l] = qmag;
      end
    end
  end

  // window mapping and output register
  logic [1:0][OutW-1:0] screen;

  wtsp_win #(.FracBits(FRAC_BITS)) u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (div_vld),
    .clip_i   (clip_sel),
    .behind_i (d_behind),
    .origin_i (origin_q),
    .extent_i (extent_q),
    .valid_o  (m_axis_tvalid),
    .screen_o (screen),
    .behind_o (m_axis_tuser)
  );

  assign m_axis_tdata = screen;

endmodule
